[src/sapp_pkg.sv]
`default_nettype none
package sapp_pkg;

    localparam int MAX_FRAME_BYTES = 15;
    localparam int VALUE_SLOTS     = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ACC_W           = 27;
    localparam int WEIGHT_W        = 28;

    localparam logic [3:0] LONG_FRAME_LEN = 4'd15;
    localparam logic [3:0] RESET_FRAME_LEN = 4'd14;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_U     = 8'h55;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;

    localparam logic [3:0] UNIT_UNKNOWN = 4'd0;
    localparam logic [3:0] UNIT_GRAM    = 4'd1;
    localparam logic [3:0] UNIT_CARAT   = 4'd2;
    localparam logic [3:0] UNIT_OUNCE   = 4'd3;
    localparam logic [3:0] UNIT_POUND   = 4'd4;
    localparam logic [3:0] UNIT_TROY_OZ = 4'd5;
    localparam logic [3:0] UNIT_PWT     = 4'd6;
    localparam logic [3:0] UNIT_GRAIN   = 4'd7;
    localparam logic [3:0] UNIT_TAEL    = 4'd8;
    localparam logic [3:0] UNIT_MOMME   = 4'd9;
    localparam logic [3:0] UNIT_TOLA    = 4'd10;
    localparam logic [3:0] UNIT_PERCENT = 4'd11;
    localparam logic [3:0] UNIT_PIECE   = 4'd12;

    localparam logic [1:0] STAT_NONE     = 2'd0;
    localparam logic [1:0] STAT_UNSTABLE = 2'd1;
    localparam logic [1:0] STAT_STABLE   = 2'd2;
    localparam logic [1:0] STAT_LIMIT    = 2'd3;

    localparam logic [ACC_W-1:0] POW10 [VALUE_SLOTS] = '{
        27'd1, 27'd10, 27'd100, 27'd1000,
        27'd10000, 27'd100000, 27'd1000000, 27'd10000000
    };

    typedef logic [VALUE_SLOTS-1:0][7:0] value_chars_t;

    // Classified frame handed from the front to the back
    typedef struct packed {
        logic         neg;
        logic         err;
        logic [3:0]   unit;
        logic [1:0]   status;
        value_chars_t chars;
    } frame_info_t;

    // Side data carried along the arithmetic stages
    typedef struct packed {
        logic       neg;
        logic       err;
        logic [3:0] dp;
        logic [3:0] unit;
        logic [1:0] status;
    } meta_t;

    function automatic logic [3:0] decode_unit(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] pair;
        logic [3:0]  code;
        pair = {a, b};
        case (pair)
            {CH_SPACE, 8'h47}: code = UNIT_GRAM;
            {8'h43, 8'h54}:    code = UNIT_CARAT;
            {8'h4F, 8'h5A}:    code = UNIT_OUNCE;
            {8'h4C, 8'h42}:    code = UNIT_POUND;
            {8'h4F, 8'h54}:    code = UNIT_TROY_OZ;
            {8'h44, 8'h57}:    code = UNIT_PWT;
            {8'h47, 8'h52}:    code = UNIT_GRAIN;
            {8'h54, 8'h4C}:    code = UNIT_TAEL;
            {8'h4D, 8'h4F}:    code = UNIT_MOMME;
            {8'h74, 8'h6F}:    code = UNIT_TOLA;
            {CH_SPACE, 8'h25}: code = UNIT_PERCENT;
            {8'h50, 8'h43}:    code = UNIT_PIECE;
            default:           code = UNIT_UNKNOWN;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

[src/sapp_front.sv]
`default_nettype none
module sapp_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,
    input  wire logic                 cfg_wr_en,
    input  wire logic [3:0]           cfg_wr_data,
    input  wire logic                 q_full,
    output logic                      q_push,
    output sapp_pkg::frame_info_t     q_data
);

    logic [7:0] win_reg  [sapp_pkg::MAX_FRAME_BYTES];
    logic [7:0] win_next [sapp_pkg::MAX_FRAME_BYTES];
    logic [3:0] frame_len_reg;
    logic       long_frame;
    logic       accept;
    logic [7:0] sign_ch;
    logic [7:0] rng_ch;
    logic [7:0] st_ch;
    logic       frame_ok;

    assign s_tready   = !q_full;
    assign accept     = s_tvalid && s_tready;
    assign long_frame = (frame_len_reg == sapp_pkg::LONG_FRAME_LEN);

    always_comb begin
        for (int i = 0; i < sapp_pkg::MAX_FRAME_BYTES - 1; i++) begin
            win_next[i] = win_reg[i+1];
        end
        win_next[sapp_pkg::MAX_FRAME_BYTES-1] = s_tdata;
    end

    // Both frame lengths end at the same place in the window
    assign sign_ch = long_frame ? win_next[0] : win_next[1];
    assign rng_ch  = win_next[11];
    assign st_ch   = win_next[12];

    always_comb begin
        frame_ok = (win_next[13] == sapp_pkg::CH_CR) && (win_next[14] == sapp_pkg::CH_LF)
            && ((sign_ch == sapp_pkg::CH_PLUS) || (sign_ch == sapp_pkg::CH_MINUS)
                || (sign_ch == sapp_pkg::CH_SPACE))
            && ((rng_ch == sapp_pkg::CH_L) || (rng_ch == sapp_pkg::CH_G)
                || (rng_ch == sapp_pkg::CH_H) || (rng_ch == sapp_pkg::CH_SPACE))
            && ((st_ch == sapp_pkg::CH_U) || (st_ch == sapp_pkg::CH_S)
                || (st_ch == sapp_pkg::CH_E) || (st_ch == sapp_pkg::CH_SPACE));
    end

    always_comb begin
        q_data.neg  = (sign_ch == sapp_pkg::CH_MINUS);
        q_data.err  = (st_ch == sapp_pkg::CH_E);
        q_data.unit = sapp_pkg::decode_unit(win_next[9], win_next[10]);
        if (st_ch == sapp_pkg::CH_U) begin
            q_data.status = sapp_pkg::STAT_UNSTABLE;
        end else if (st_ch == sapp_pkg::CH_S) begin
            q_data.status = sapp_pkg::STAT_STABLE;
        end else if (st_ch == sapp_pkg::CH_E) begin
            q_data.status = sapp_pkg::STAT_LIMIT;
        end else begin
            q_data.status = sapp_pkg::STAT_NONE;
        end
        for (int k = 0; k < sapp_pkg::VALUE_SLOTS; k++) begin
            q_data.chars[k] = win_next[k+1];
        end
        // Short frames hold the sign in the first slot: treat it as blank
        if (!long_frame) begin
            q_data.chars[0] = sapp_pkg::CH_SPACE;
        end
    end

    assign q_push = accept && frame_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_len_reg <= sapp_pkg::RESET_FRAME_LEN;
            for (int i = 0; i < sapp_pkg::MAX_FRAME_BYTES; i++) begin
                win_reg[i] <= 8'd0;
            end
        end else begin
            if (cfg_wr_en) begin
                frame_len_reg <= cfg_wr_data;
            end
            if (accept) begin
                win_reg <= win_next;
            end
        end
    end

endmodule
`default_nettype wire

[src/sapp_fifo.sv]
`default_nettype none
module sapp_fifo (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire sapp_pkg::frame_info_t push_data,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       empty,
    output sapp_pkg::frame_info_t      head
);

    sapp_pkg::frame_info_t mem_reg [sapp_pkg::QUEUE_DEPTH];
    logic [sapp_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [sapp_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [sapp_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic do_push;
    logic do_pop;

    assign full    = (count_reg == sapp_pkg::QUEUE_CNT_W'(sapp_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[src/sapp_back.sv]
`default_nettype none
module sapp_back (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  q_empty,
    input  wire sapp_pkg::frame_info_t q_head,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [39:0]                m_tdata
);

    localparam int NS = sapp_pkg::VALUE_SLOTS;
    localparam int AW = sapp_pkg::ACC_W;

    logic adv;

    // Stage A: per-slot digit and its decimal exponent
    logic                a_valid_reg;
    sapp_pkg::meta_t     a_meta_reg, a_meta_next;
    logic [3:0]          a_dig_reg [NS];
    logic [3:0]          a_dig_next [NS];
    logic [2:0]          a_exp_reg [NS];
    logic [2:0]          a_exp_next [NS];

    // Stage B: weighted digits
    logic                b_valid_reg;
    sapp_pkg::meta_t     b_meta_reg;
    logic [AW-1:0]       b_prod_reg [NS];

    // Stage C: two partial sums
    logic                c_valid_reg;
    sapp_pkg::meta_t     c_meta_reg;
    logic [AW-1:0]       c_lo_reg;
    logic [AW-1:0]       c_hi_reg;

    // Output register
    logic                          m_valid_reg;
    logic [sapp_pkg::WEIGHT_W-1:0] m_weight_reg, m_weight_next;
    logic [3:0]                    m_dp_reg;
    logic [3:0]                    m_unit_reg;
    logic [1:0]                    m_status_reg;
    logic [AW-1:0]                 acc;

    assign adv   = !m_valid_reg || m_tready;
    assign q_pop = adv && !q_empty;

    always_comb begin
        logic       alive;
        logic       seen_dot;
        logic       first_dot;
        logic [3:0] dp;
        logic [3:0] frac;
        logic [3:0] after;
        logic [3:0] scale;
        logic [3:0] e;
        logic [7:0] c;
        logic       is_dig;
        logic       is_sp;
        logic       is_dot;
        logic [NS-1:0] cnt;
        alive     = 1'b1;
        seen_dot  = 1'b0;
        first_dot = 1'b0;
        dp        = 4'd0;
        frac      = 4'd0;
        cnt       = '0;
        for (int k = 0; k < NS; k++) begin
            c      = q_head.chars[k];
            is_dig = (c >= sapp_pkg::CH_ZERO) && (c <= sapp_pkg::CH_NINE);
            is_sp  = (c == sapp_pkg::CH_SPACE);
            is_dot = (c == sapp_pkg::CH_DOT);
            // Place count follows the first point, even past the end of the number
            if (is_dot && !first_dot) begin
                first_dot = 1'b1;
                dp        = 4'(NS - 1 - k);
            end
            if (alive && !is_sp) begin
                if (is_dig) begin
                    cnt[k] = 1'b1;
                    if (seen_dot) begin
                        frac = frac + 4'd1;
                    end
                end else if (is_dot && !seen_dot) begin
                    seen_dot = 1'b1;
                end else begin
                    alive = 1'b0;
                end
            end
            a_dig_next[k] = cnt[k] ? c[3:0] : 4'd0;
        end
        scale = dp - frac;
        after = 4'd0;
        for (int k = NS - 1; k >= 0; k--) begin
            e             = after + scale;
            a_exp_next[k] = e[2:0];
            if (cnt[k]) begin
                after = after + 4'd1;
            end
        end
        a_meta_next.neg    = q_head.neg;
        a_meta_next.err    = q_head.err;
        a_meta_next.dp     = q_head.err ? 4'd0 : dp;
        a_meta_next.unit   = q_head.unit;
        a_meta_next.status = q_head.status;
    end

    assign acc = c_lo_reg + c_hi_reg;

    always_comb begin
        if (c_meta_reg.err) begin
            m_weight_next = '0;
        end else if (c_meta_reg.neg) begin
            m_weight_next = '0 - {1'b0, acc};
        end else begin
            m_weight_next = {1'b0, acc};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_meta_reg <= a_meta_next;
            a_dig_reg  <= a_dig_next;
            a_exp_reg  <= a_exp_next;
            b_meta_reg <= a_meta_reg;
            for (int k = 0; k < NS; k++) begin
                b_prod_reg[k] <= AW'({{(AW-4){1'b0}}, a_dig_reg[k]}
                                     * sapp_pkg::POW10[a_exp_reg[k]]);
            end
            c_meta_reg   <= b_meta_reg;
            c_lo_reg     <= b_prod_reg[0] + b_prod_reg[1] + b_prod_reg[2] + b_prod_reg[3];
            c_hi_reg     <= b_prod_reg[4] + b_prod_reg[5] + b_prod_reg[6] + b_prod_reg[7];
            m_weight_reg <= m_weight_next;
            m_dp_reg     <= c_meta_reg.dp;
            m_unit_reg   <= c_meta_reg.unit;
            m_status_reg <= c_meta_reg.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= !q_empty;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            m_valid_reg <= c_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_status_reg, m_unit_reg, m_dp_reg, m_weight_reg};

endmodule
`default_nettype wire

[src/scale_ascii_packet_parser.sv]
// Channel   Dir  Ports                        Item
// s_        in   s_tvalid s_tready s_tdata    one received byte: tdata[7:0] rx_byte
// m_        out  m_tvalid m_tready m_tdata    one parsed frame (fields at the m_tdata port)
// cfg_      in   cfg_wr_en cfg_wr_data        frame_length, 15 = 15-byte frames, else 14
//
// One byte is taken each cycle while the two-entry frame queue has room.
// A completed frame is classified and queued as its LF byte is taken, then registered in turn
// through digit weighting, digit products, partial sums and the output register on m_.
// Reset (aresetn low, synchronous) clears the byte window to zeros and sets 14-byte frames.
// A stalled m_ side holds the arithmetic stages; the input stalls only once the queue fills.
`default_nettype none
module scale_ascii_packet_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,     // [27:0] weight_value, [31:28] decimal_places,
                                          // [35:32] unit_code, [37:36] status_code
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data
);

    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_empty;
    sapp_pkg::frame_info_t q_in;
    sapp_pkg::frame_info_t q_head;

    sapp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    sapp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    sapp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire
